/* rtl/ole_pkg.sv */
// Package with shared types and constants for the ordered list engine.
`timescale 1ns / 1ps
package ole_pkg;
    localparam int CAPACITY_DEF    = 32;
    localparam int VALUE_WIDTH_DEF = 32;
    localparam int REQ_W   = 3;
    localparam int POS_W   = 6;
    localparam int FPOS_W  = 5;
    localparam int TOTAL_W = 6;
    localparam int DATA_W  = 32;

    typedef enum logic [REQ_W-1:0] {
        REQ_PUSH_FRONT = 3'd0,
        REQ_PUSH_BACK  = 3'd1,
        REQ_POP_FRONT  = 3'd2,
        REQ_POP_BACK   = 3'd3,
        REQ_INSERT_AT  = 3'd4,
        REQ_REMOVE_AT  = 3'd5,
        REQ_FIND       = 3'd6,
        REQ_NONE       = 3'd7
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_SCAN,
        ST_REPLY
    } state_t;

    // Controller to datapath.
    typedef struct packed {
        logic load;      // capture request
        logic exec;      // apply insert/remove/pop
        logic scan;      // one compare step of find
    } ctrl_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic is_find;
        logic scan_done;
    } ctrl_sts_t;
endpackage

/* rtl/ole_ctrl.sv */
// Controller state machine for the ordered list engine.
`timescale 1ns / 1ps
module ole_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    output logic               out_valid,
    input  logic               out_ready,
    output ole_pkg::ctrl_cmd_t cmd,
    input  ole_pkg::ctrl_sts_t sts
);
    import ole_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                state_next = sts.is_find ? ST_SCAN : ST_REPLY;
            end
            ST_SCAN: begin
                if (sts.scan_done) begin
                    state_next = ST_REPLY;
                end
            end
            ST_REPLY: begin
                if (out_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        in_ready  = 1'b0;
        out_valid = 1'b0;
        cmd       = '0;
        case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_EXEC: begin
                cmd.exec = 1'b1;
            end
            ST_SCAN: begin
                cmd.scan = 1'b1;
            end
            ST_REPLY: begin
                out_valid = 1'b1;
            end
            default: ;
        endcase
    end
endmodule

/* rtl/ole_datapath.sv */
// Datapath of the ordered list engine: shifting cell row and find scan.
`timescale 1ns / 1ps
module ole_datapath #(
    parameter int CAPACITY    = ole_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = ole_pkg::VALUE_WIDTH_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  ole_pkg::ctrl_cmd_t           cmd,
    output ole_pkg::ctrl_sts_t           sts,
    input  logic [ole_pkg::REQ_W-1:0]    req_type,
    input  logic [ole_pkg::POS_W-1:0]    position,
    input  logic [ole_pkg::DATA_W-1:0]   value,
    output logic                         ok,
    output logic [ole_pkg::FPOS_W-1:0]   found_position,
    output logic [ole_pkg::TOTAL_W-1:0]  item_total
);
    import ole_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);

    logic [VALUE_WIDTH-1:0] cells_reg [CAPACITY];
    logic [CNT_W-1:0]       count_reg;
    logic [CNT_W-1:0]       scan_reg;
    req_t                   req_reg;
    logic [POS_W-1:0]       pos_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic                   ok_reg;
    logic [FPOS_W-1:0]      fpos_reg;

    logic             full, empty, do_ins, do_rem;
    logic [CNT_W:0]   at;
    logic [CNT_W-1:0] at_c;
    logic [DATA_W+VALUE_WIDTH-1:0] val_ext;

    assign val_ext = {{VALUE_WIDTH{1'b0}}, value};
    assign full  = count_reg >= CNT_W'(CAPACITY);
    assign empty = count_reg == '0;

    always_comb begin
        do_ins = 1'b0;
        do_rem = 1'b0;
        at     = '0;
        case (req_reg)
            REQ_PUSH_FRONT: do_ins = !full;
            REQ_PUSH_BACK: begin
                do_ins = !full;
                at     = {1'b0, count_reg};
            end
            REQ_POP_FRONT: do_rem = !empty;
            REQ_POP_BACK: begin
                do_rem = !empty;
                at     = {1'b0, count_reg} - 1'b1;
            end
            REQ_INSERT_AT: begin
                do_ins = !full && ({1'b0, count_reg} >= (CNT_W+1)'(pos_reg));
                at     = (CNT_W+1)'(pos_reg);
            end
            REQ_REMOVE_AT: begin
                do_rem = ({1'b0, count_reg} > (CNT_W+1)'(pos_reg));
                at     = (CNT_W+1)'(pos_reg);
            end
            default: ;
        endcase
    end
    assign at_c = at[CNT_W-1:0];

    assign sts.is_find   = (req_reg == REQ_FIND);
    assign sts.scan_done = ok_reg || (scan_reg >= count_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg <= req_t'(req_type);
            pos_reg <= position;
            val_reg <= val_ext[VALUE_WIDTH-1:0];
        end
        if (cmd.exec) begin
            for (int i = 0; i < CAPACITY; i++) begin
                if (do_ins) begin
                    if (CNT_W'(i) == at_c) begin
                        cells_reg[i] <= val_reg;
                    end else if (i > 0 && CNT_W'(i) > at_c) begin
                        cells_reg[i] <= cells_reg[(i > 0) ? i - 1 : 0];
                    end
                end else if (do_rem) begin
                    if (i < CAPACITY - 1 && CNT_W'(i) >= at_c) begin
                        cells_reg[i] <= cells_reg[(i < CAPACITY - 1) ? i + 1 : i];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            ok_reg    <= 1'b0;
            fpos_reg  <= '0;
            scan_reg  <= '0;
        end else if (cmd.exec) begin
            ok_reg   <= do_ins || do_rem;
            fpos_reg <= '0;
            scan_reg <= '0;
            if (do_ins) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rem) begin
                count_reg <= count_reg - 1'b1;
            end
        end else if (cmd.scan && !sts.scan_done) begin
            // One cell compared per cycle; the scan stops at the first hit.
            if (cells_reg[scan_reg[IDX_W-1:0]] == val_reg) begin
                ok_reg   <= 1'b1;
                fpos_reg <= FPOS_W'(scan_reg);
            end else begin
                scan_reg <= scan_reg + 1'b1;
            end
        end
    end

    assign ok             = ok_reg;
    assign found_position = fpos_reg;
    assign item_total     = TOTAL_W'(count_reg);
endmodule

/* rtl/ordered_list_engine.sv */
// Top level of the ordered list engine.
`timescale 1ns / 1ps
// Channel   Direction  tdata (low bit up)                       tuser
// s_axis    in         req_type[2:0], position[8:3], value[40:9]  -
// m_axis    out        ok[0], found_position[5:1], item_total[11:6] -
//
// A request is taken in the idle state, the cell row is updated in the next
// cycle, and the reply word is offered from the reply state on. A find then
// walks the cells one per cycle through the single compare unit, stopping at
// the first hit or after the last item, before the reply word is offered.
// Reset (aresetn low, synchronous) empties the list; the cells are not cleared.
// A stalled reply holds its word until m_axis_tready is high.
module ordered_list_engine #(
    parameter int CAPACITY    = ole_pkg::CAPACITY_DEF,
    parameter int VALUE_WIDTH = ole_pkg::VALUE_WIDTH_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // req_type, position, value, zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata   // ok, found_position, item_total, zero pad
);
    import ole_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;
    logic               ok;
    logic [FPOS_W-1:0]  found_position;
    logic [TOTAL_W-1:0] item_total;

    // The controller sequences load, execute, scan and reply.
    ole_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .cmd       (cmd),
        .sts       (sts)
    );

    // The datapath holds the cell row, the count and the reply registers.
    ole_datapath #(
        .CAPACITY    (CAPACITY),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .req_type       (s_axis_tdata[2:0]),
        .position       (s_axis_tdata[8:3]),
        .value          (s_axis_tdata[40:9]),
        .ok             (ok),
        .found_position (found_position),
        .item_total     (item_total)
    );

    assign m_axis_tdata = {4'b0, item_total, found_position, ok};
endmodule
